>>> rtl/branch_target_buffer_predictor_macros.svh
// Assertion macros shared by the branch target buffer RTL.
// No dependencies; include by bare file name where assertions are written.
`ifndef BRANCH_TARGET_BUFFER_PREDICTOR_MACROS_SVH
`define BRANCH_TARGET_BUFFER_PREDICTOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BTBP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("btbp same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BTBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("btbp next-cycle check failed");

`endif

>>> rtl/btbp_pkg.sv
// Shared types and constants for the branch target buffer predictor.
// No dependencies; used by btbp_counter and branch_target_buffer_predictor.
package btbp_pkg;

	localparam int ADDR_W     = 32;
	localparam int PORT_IDX_W = 4;
	localparam int KIND_W     = 2;
	localparam int CTR_W      = 2;

	// predictor_kind codes; the unused code behaves as the two-bit counter
	localparam logic [KIND_W-1:0] KIND_ONE_BIT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_TWO_BIT = 2'd1;
	localparam logic [KIND_W-1:0] KIND_HYST    = 2'd2;

	localparam logic [ADDR_W-1:0] INSTR_BYTES = 32'd4;

	typedef logic [CTR_W-1:0] ctr_t;

	localparam ctr_t CTR_ZERO      = 2'd0;
	localparam ctr_t CTR_ONE       = 2'd1;
	localparam ctr_t CTR_ALLOC_TWO = 2'd2;

	// Direction predictor outcome for one entry
	typedef struct packed {
		logic pred;   // current state predicts taken
		logic miss;   // resolved outcome disagrees with pred
		ctr_t nxt;    // state after the resolved outcome
	} ctr_res_t;

endpackage

>>> rtl/btbp_counter.sv
// Direction predictor: prediction and next state of one entry's counter.
// Depends on btbp_pkg.
module btbp_counter (
	input  logic [btbp_pkg::KIND_W-1:0] kind,
	input  btbp_pkg::ctr_t              state,
	input  logic                        taken,
	output btbp_pkg::ctr_res_t          res
);

	logic one_bit;
	logic two_bit;
	logic pred;

	always_comb begin
		unique case (kind)
			btbp_pkg::KIND_ONE_BIT: begin
				one_bit = 1'b1;
				two_bit = 1'b0;
			end
			btbp_pkg::KIND_HYST: begin
				one_bit = 1'b0;
				two_bit = 1'b0;
			end
			default: begin
				one_bit = 1'b0;
				two_bit = 1'b1;
			end
		endcase
	end

	assign pred = one_bit ? (state != btbp_pkg::CTR_ZERO) : state[1];

	always_comb begin
		res.pred = pred;
		res.miss = 1'b0;
		res.nxt  = state;
		if (taken && !pred) begin
			res.miss = 1'b1;
			res.nxt  = two_bit ? (state + btbp_pkg::CTR_ONE) : btbp_pkg::CTR_ONE;
		end else if (!taken && pred) begin
			res.miss = 1'b1;
			res.nxt  = two_bit ? (state - btbp_pkg::CTR_ONE) : btbp_pkg::CTR_ZERO;
		end
	end

endmodule

>>> rtl/branch_target_buffer_predictor.sv
// Fully associative branch target buffer with selectable direction predictor.
// Depends on btbp_pkg, btbp_counter and branch_target_buffer_predictor_macros.svh.
//
// Channel   | Handshake                     | Payload
// ----------+-------------------------------+-------------------------------------------
// item in   | start & !busy                 | mode pc had_hit entry_index taken target_addr
// result    | done (one-cycle strobe)       | hit predict_taken found_index
//           |                               | predicted_target mispredict corrected_pc
// config    | predictor_kind_we             | predictor_kind_wdata
//
// One item per cycle; busy never rises. An accepted transaction passes through the
// item input register and then the result register before done shows its result.
// The rate is set by the single pass through the parallel tag compare, the
// priority pick of the lowest matching entry and the one state write port.
// Reset (arst_n low) clears the valid bits, fill pointer and predictor_kind
// (to the two-bit counter); tags, targets and counters stay undefined until written.
// The receiver cannot stall: each result is held for exactly one cycle.
`include "branch_target_buffer_predictor_macros.svh"

module branch_target_buffer_predictor #(
	parameter int ENTRIES = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// item channel
	input  logic                                start,
	output logic                                busy,
	input  logic                                mode,
	input  logic [btbp_pkg::ADDR_W-1:0]         pc,
	input  logic                                had_hit,
	input  logic [btbp_pkg::PORT_IDX_W-1:0]     entry_index,
	input  logic                                taken,
	input  logic [btbp_pkg::ADDR_W-1:0]         target_addr,
	// configuration
	input  logic                                predictor_kind_we,
	input  logic [btbp_pkg::KIND_W-1:0]         predictor_kind_wdata,
	// result channel
	output logic                                done,
	output logic                                hit,
	output logic                                predict_taken,
	output logic [btbp_pkg::PORT_IDX_W-1:0]     found_index,
	output logic [btbp_pkg::ADDR_W-1:0]         predicted_target,
	output logic                                mispredict,
	output logic [btbp_pkg::ADDR_W-1:0]         corrected_pc
);

	// IW indexes the entry array; EW is wide enough to hold both a port index
	// and the entry count, for range checks and found_index truncation.
	localparam int IW = $clog2(ENTRIES);
	localparam int EW = ((IW > btbp_pkg::PORT_IDX_W) ? IW : btbp_pkg::PORT_IDX_W) + 1;

	// Item input register
	logic                            valid_s1;
	logic                            mode_s1;
	logic [btbp_pkg::ADDR_W-1:0]     pc_s1;
	logic                            had_hit_s1;
	logic [btbp_pkg::PORT_IDX_W-1:0] entry_index_s1;
	logic                            taken_s1;
	logic [btbp_pkg::ADDR_W-1:0]     target_addr_s1;

	// Configuration and table state
	logic [btbp_pkg::KIND_W-1:0]     predictor_kind_q;
	logic [ENTRIES-1:0]              entry_valid_q;
	logic [btbp_pkg::ADDR_W-1:0]     entry_tag_q    [ENTRIES];
	logic [btbp_pkg::ADDR_W-1:0]     entry_target_q [ENTRIES];
	btbp_pkg::ctr_t                  counter_q      [ENTRIES];
	logic [IW-1:0]                   fill_ptr_q;

	// Result register
	logic                            done_q;
	logic                            hit_q;
	logic                            predict_taken_q;
	logic [btbp_pkg::PORT_IDX_W-1:0] found_index_q;
	logic [btbp_pkg::ADDR_W-1:0]     predicted_target_q;
	logic                            mispredict_q;
	logic [btbp_pkg::ADDR_W-1:0]     corrected_pc_q;

	// Datapath
	logic                            accept;
	logic [ENTRIES-1:0]              match;
	logic                            any_match;
	logic [IW-1:0]                   hit_idx;
	logic [EW-1:0]                   hit_idx_ext;
	logic [EW-1:0]                   upd_idx_ext;
	logic [IW-1:0]                   upd_idx;
	logic                            upd_in_range;
	logic [IW-1:0]                   rd_idx;
	btbp_pkg::ctr_res_t              ctr_res;
	logic                            is_lookup;
	logic                            is_upd_hit;
	logic                            is_upd_miss;
	btbp_pkg::ctr_t                  alloc_state;

	// The block takes a transaction every cycle
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Capture the transaction; payload needs no reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1        <= mode;
			pc_s1          <= pc;
			had_hit_s1     <= had_hit;
			entry_index_s1 <= entry_index;
			taken_s1       <= taken;
			target_addr_s1 <= target_addr;
		end
	end

	// Configuration register; to be written only while idle, which the block does not enforce
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			predictor_kind_q <= btbp_pkg::KIND_TWO_BIT;
		end else if (predictor_kind_we) begin
			predictor_kind_q <= predictor_kind_wdata;
		end
	end

	// Compare the pc against every valid entry at once
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			match[i] = entry_valid_q[i] && (entry_tag_q[i] == pc_s1);
		end
	end

	assign any_match = |match;

	// Lowest matching index wins: scan downward so the last write is the lowest
	always_comb begin
		hit_idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit_idx = IW'(i);
			end
		end
	end

	assign hit_idx_ext = EW'(hit_idx);

	// Update index from the earlier lookup; out-of-range slots change nothing
	assign upd_idx_ext  = EW'(entry_index_s1);
	assign upd_in_range = upd_idx_ext < EW'(ENTRIES);
	assign upd_idx      = upd_idx_ext[IW-1:0];

	assign is_lookup   = valid_s1 && !mode_s1;
	assign is_upd_hit  = valid_s1 && mode_s1 && had_hit_s1 && upd_in_range;
	assign is_upd_miss = valid_s1 && mode_s1 && !had_hit_s1;

	// One counter read: the matched entry on lookup, the named entry on update
	assign rd_idx = mode_s1 ? upd_idx : hit_idx;

	btbp_counter u_counter (
		.kind  (predictor_kind_q),
		.state (counter_q[rd_idx]),
		.taken (taken_s1),
		.res   (ctr_res)
	);

	assign alloc_state = (predictor_kind_q == btbp_pkg::KIND_ONE_BIT) ?
		btbp_pkg::CTR_ONE : btbp_pkg::CTR_ALLOC_TWO;

	// Valid bits and fill pointer: allocate on an update that missed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
			fill_ptr_q    <= '0;
		end else if (is_upd_miss) begin
			entry_valid_q[fill_ptr_q] <= 1'b1;
			if (fill_ptr_q == IW'(ENTRIES - 1)) begin
				fill_ptr_q <= '0;
			end else begin
				fill_ptr_q <= fill_ptr_q + IW'(1);
			end
		end
	end

	// Entry payload; undefined until written, so no reset
	always_ff @(posedge clk) begin
		if (is_upd_miss) begin
			entry_tag_q[fill_ptr_q]    <= pc_s1;
			entry_target_q[fill_ptr_q] <= target_addr_s1;
			counter_q[fill_ptr_q]      <= alloc_state;
		end else if (is_upd_hit) begin
			counter_q[upd_idx] <= ctr_res.nxt;
		end
	end

	// Result register: fields not driven by the item type read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q       <= 1'b0;
			hit_q        <= 1'b0;
			mispredict_q <= 1'b0;
		end else begin
			done_q       <= valid_s1;
			hit_q        <= is_lookup && any_match;
			mispredict_q <= is_upd_miss || (is_upd_hit && ctr_res.miss);
		end
	end

	always_ff @(posedge clk) begin
		predict_taken_q    <= is_lookup && any_match && ctr_res.pred;
		found_index_q      <= (is_lookup && any_match) ?
			hit_idx_ext[btbp_pkg::PORT_IDX_W-1:0] : '0;
		predicted_target_q <= (is_lookup && any_match) ? entry_target_q[hit_idx] : '0;
		if (is_upd_miss || (is_upd_hit && ctr_res.miss && taken_s1)) begin
			corrected_pc_q <= target_addr_s1;
		end else if (is_upd_hit && ctr_res.miss) begin
			corrected_pc_q <= pc_s1 + btbp_pkg::INSTR_BYTES;
		end else begin
			corrected_pc_q <= '0;
		end
	end

	assign done             = done_q;
	assign hit              = hit_q;
	assign predict_taken    = predict_taken_q;
	assign found_index      = found_index_q;
	assign predicted_target = predicted_target_q;
	assign mispredict       = mispredict_q;
	assign corrected_pc     = corrected_pc_q;

	// Every accepted transaction yields its result with a done strobe
	`BTBP_ASSERT_NEXT(a_result_follows, clk, arst_n, accept, (##1 done))
	// No hit or mispredict flag outside a result strobe
	`BTBP_ASSERT_IMPL(a_quiet_when_idle, clk, arst_n, !done, (!hit && !mispredict))
	// Lookup and update results never mix
	`BTBP_ASSERT_IMPL(a_hit_no_mispredict, clk, arst_n, hit, !mispredict)
	// An allocation makes its slot valid
	`BTBP_ASSERT_NEXT(a_alloc_valid, clk, arst_n, is_upd_miss, entry_valid_q[$past(fill_ptr_q)])

endmodule
